// ----- hdl/periodic_tick_dispatcher_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the periodic tick dispatcher
// Concurrent check wrappers; the checks drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TICK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TICK_DISPATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define PTD_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("ptd check failed: always");
// antecedent implies consequent in the next cycle
`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ptd check failed: next");
`else
`define PTD_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TICK_W      = 32;
  localparam int PER_W       = 16;
  localparam int ID_W        = 8;
  localparam int DIV_CNT_W   = $clog2(TICK_W);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_TICK      = 2'd0,
    ST_DONE      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_T_ENTRY,
    S_T_DIV,
    S_T_CHECK
  } state_t;

  typedef struct packed {
    logic         load_in;
    logic         inc_tick;
    logic         clr_idx;
    logic         inc_idx;
    logic         append;
    logic         set_period;
    logic         shift_step;
    logic         dec_count;
    logic         div_start;
    logic         div_step;
    logic         capture_pend;
    logic         emit_pend;
    logic         pend_last;
    logic         emit_resp;
    status_code_t resp_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      full;
    logic      idx_end;
    logic      shift_end;
    logic      id_match;
    logic      per_zero;
    logic      div_done;
    logic      rem_zero;
    logic      pend_valid;
  } dp_stat_t;

endpackage

// ----- hdl/ptd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer for commands, table search/shift and the tick walk.
// ----------------------------------------------------------------------------
module ptd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptd_pkg::dp_stat_t stat,
  output ptd_pkg::dp_cmd_t  cmd
);
  import ptd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_TICK: state_nxt = S_T_ENTRY;
          CMD_ADD:  state_nxt = S_IDLE;
          default:  state_nxt = S_SEARCH;
        endcase
      end
      S_SEARCH: begin
        if (stat.idx_end) state_nxt = S_IDLE;
        else if (stat.id_match) state_nxt = (stat.cmd == CMD_CHANGE) ? S_IDLE : S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_end) state_nxt = S_IDLE;
      end
      S_T_ENTRY: begin
        if (stat.idx_end) state_nxt = S_IDLE;
        else if (!stat.per_zero) state_nxt = S_T_DIV;
      end
      S_T_DIV: begin
        if (stat.div_done) state_nxt = S_T_CHECK;
      end
      S_T_CHECK: state_nxt = S_T_ENTRY;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load_in = start;
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_TICK: begin
            cmd.inc_tick = 1'b1;
            cmd.clr_idx  = 1'b1;
          end
          CMD_ADD: begin
            cmd.emit_resp   = 1'b1;
            cmd.append      = !stat.full;
            cmd.resp_status = stat.full ? ST_FULL : ST_DONE;
          end
          default: cmd.clr_idx = 1'b1;
        endcase
      end
      S_SEARCH: begin
        if (stat.idx_end) begin
          cmd.emit_resp   = 1'b1;
          cmd.resp_status = ST_NOT_FOUND;
        end else if (stat.id_match) begin
          if (stat.cmd == CMD_CHANGE) begin
            cmd.set_period  = 1'b1;
            cmd.emit_resp   = 1'b1;
            cmd.resp_status = ST_DONE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          cmd.dec_count   = 1'b1;
          cmd.emit_resp   = 1'b1;
          cmd.resp_status = ST_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_T_ENTRY: begin
        if (stat.idx_end) begin
          // flush the held dispatch as the final one
          cmd.emit_pend = stat.pend_valid;
          cmd.pend_last = 1'b1;
        end else if (stat.per_zero) begin
          cmd.inc_idx = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_T_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_T_CHECK: begin
        cmd.inc_idx = 1'b1;
        if (stat.rem_zero) begin
          cmd.emit_pend    = stat.pend_valid;
          cmd.capture_pend = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/ptd_datapath.sv -----
// ----------------------------------------------------------------------------
// ptd_datapath
// Entry table, tick counter, serial remainder unit and result registers.
// ----------------------------------------------------------------------------
`include "periodic_tick_dispatcher_assert.svh"
module ptd_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [1:0]                in_command,
  input  logic [ptd_pkg::ID_W-1:0]  in_subscriber_id,
  input  logic [ptd_pkg::PER_W-1:0] in_period,
  input  logic [31:0]               in_payload,
  input  ptd_pkg::dp_cmd_t          cmd,
  output ptd_pkg::dp_stat_t         stat,
  output logic                      out_valid,
  output logic [ptd_pkg::ID_W-1:0]  out_fired_id,
  output logic [31:0]               out_tick_payload,
  output logic [1:0]                out_status,
  output logic                      out_last
);
  import ptd_pkg::*;

  logic [ID_W-1:0]   ids_r  [MAX_ENTRIES];
  logic [PER_W-1:0]  pers_r [MAX_ENTRIES];

  cmd_code_t         cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [PER_W-1:0]  per_r;
  logic [31:0]       pay_r;

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  idx_a, idx_b;
  logic [CNT_W:0]    idx_p1;

  logic [PER_W-1:0]     rem_r;
  logic [TICK_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic [PER_W:0]       trial;
  logic [PER_W:0]       diff;
  logic [PER_W-1:0]     divisor;

  logic              pend_valid_r;
  logic [ID_W-1:0]   pend_id_r;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [31:0]       out_pay_r;
  logic [1:0]        out_status_r;
  logic              out_last_r;

  assign idx_a   = idx_r[IDX_W-1:0];
  assign idx_p1  = {1'b0, idx_r} + (CNT_W+1)'(1);
  assign idx_b   = idx_p1[IDX_W-1:0];
  assign divisor = pers_r[idx_a];
  assign trial   = {rem_r, quo_r[TICK_W-1]};
  assign diff    = trial - {1'b0, divisor};

  assign stat.cmd        = cmd_r;
  assign stat.full       = (count_r == CNT_W'(MAX_ENTRIES));
  assign stat.idx_end    = (idx_r >= count_r);
  assign stat.shift_end  = (idx_p1 >= {1'b0, count_r});
  assign stat.id_match   = (ids_r[idx_a] == id_r);
  assign stat.per_zero   = (divisor == '0);
  assign stat.div_done   = (dcnt_r == DIV_CNT_W'(TICK_W - 1));
  assign stat.rem_zero   = (rem_r == '0);
  assign stat.pend_valid = pend_valid_r;

  always_comb begin
    tick_nxt  = tick_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.inc_tick) tick_nxt = tick_r + TICK_W'(1);
    if (cmd.append) count_nxt = count_r + CNT_W'(1);
    else if (cmd.dec_count) count_nxt = count_r - CNT_W'(1);
    if (cmd.clr_idx) idx_nxt = '0;
    else if (cmd.inc_idx || cmd.shift_step) idx_nxt = idx_p1[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.emit_resp || cmd.emit_pend;
      if (cmd.inc_tick) pend_valid_r <= 1'b0;
      else if (cmd.capture_pend) pend_valid_r <= 1'b1;
    end
  end

  // payload, table, remainder and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= cmd_code_t'(in_command);
      id_r  <= in_subscriber_id;
      per_r <= in_period;
      pay_r <= in_payload;
    end
    if (cmd.append) begin
      ids_r[count_r[IDX_W-1:0]]  <= id_r;
      pers_r[count_r[IDX_W-1:0]] <= per_r;
    end
    if (cmd.set_period) pers_r[idx_a] <= per_r;
    if (cmd.shift_step) begin
      ids_r[idx_a]  <= ids_r[idx_b];
      pers_r[idx_a] <= pers_r[idx_b];
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= tick_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      // restoring step: one dividend bit per cycle
      rem_r  <= diff[PER_W] ? trial[PER_W-1:0] : diff[PER_W-1:0];
      quo_r  <= {quo_r[TICK_W-2:0], 1'b0};
      dcnt_r <= dcnt_r + DIV_CNT_W'(1);
    end
    if (cmd.capture_pend) pend_id_r <= ids_r[idx_a];
    if (cmd.emit_pend) begin
      out_id_r     <= pend_id_r;
      out_pay_r    <= pay_r;
      out_status_r <= ST_TICK;
      out_last_r   <= cmd.pend_last;
    end else if (cmd.emit_resp) begin
      out_id_r     <= id_r;
      out_pay_r    <= '0;
      out_status_r <= cmd.resp_status;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired_id     = out_id_r;
  assign out_tick_payload = out_pay_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  `PTD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(MAX_ENTRIES))
  `PTD_ASSERT_ALWAYS(a_no_append_full, clk, rst_n, !(cmd.append && stat.full))
  `PTD_ASSERT_ALWAYS(a_emit_needs_pend, clk, rst_n, !cmd.emit_pend || pend_valid_r)
  `PTD_ASSERT_NEXT(a_emit_strobe, clk, rst_n, cmd.emit_resp || cmd.emit_pend, out_valid_r)

endmodule

// ----- hdl/periodic_tick_dispatcher.sv -----
// ----------------------------------------------------------------------------
// periodic_tick_dispatcher
// Subscriber table with a shared tick counter and in-order tick dispatch.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Busy then stays
// high until the final result is registered, and that result is on the ports
// in the first cycle that busy is low. Results appear for one cycle each with
// out_valid, and the receiver cannot stall them. An add is answered from the
// dispatch state. Change and remove search the table from entry zero until a
// match or its end; remove then shifts every entry behind the match down.
// A tick walks the table one entry at a time. Each entry with nonzero period
// runs a bit-serial remainder of the tick count and is dispatched when it is
// zero; a zero-period entry is skipped. Each dispatch is held in a pending
// register until the next one is found, so the final one can carry out_last.
module periodic_tick_dispatcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_subscriber_id,
  input  logic [15:0] in_period,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  output logic [7:0]  out_fired_id,
  output logic [31:0] out_tick_payload,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import ptd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ptd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_subscriber_id (in_subscriber_id),
    .in_period        (in_period),
    .in_payload       (in_payload),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_fired_id     (out_fired_id),
    .out_tick_payload (out_tick_payload),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule
